// ===== rtl/core/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg - frustum cull shared definitions
// Plane register layout, coefficient format and config index width.
// ----------------------------------------------------------------------------
package afc_pkg;

	localparam int PLANE_COUNT       = 6;
	localparam int COEF_WIDTH        = 16;
	localparam int COEF_COUNT        = 4;
	localparam int PLANE_WIDTH       = COEF_WIDTH * COEF_COUNT;
	localparam int TAG_WIDTH         = 16;
	localparam int COORD_WIDTH_DEF   = 16;
	localparam int CFG_INDEX_WIDTH   = $clog2(PLANE_COUNT);
	localparam int AXIS_COUNT        = 3;

	// coefficient slots within a plane register
	typedef enum logic [1:0] {
		COEF_A = 2'd0,
		COEF_B = 2'd1,
		COEF_C = 2'd2,
		COEF_D = 2'd3
	} coef_slot_t;

	function automatic logic [COEF_WIDTH-1:0] coef_at(input logic [PLANE_WIDTH-1:0] plane,
		input coef_slot_t slot);
		coef_at = plane[slot*COEF_WIDTH +: COEF_WIDTH];
	endfunction

endpackage

// ===== rtl/core/afc_if.sv =====
// ----------------------------------------------------------------------------
// afc_if - box and result channels
// Valid/ready channels carrying one box word in and one result word out.
// ----------------------------------------------------------------------------
interface afc_box_if #(
	parameter int COORD_WIDTH = 16
);
	import afc_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] box_min_x;
	logic signed [COORD_WIDTH-1:0] box_min_y;
	logic signed [COORD_WIDTH-1:0] box_min_z;
	logic signed [COORD_WIDTH-1:0] box_max_x;
	logic signed [COORD_WIDTH-1:0] box_max_y;
	logic signed [COORD_WIDTH-1:0] box_max_z;
	logic        [TAG_WIDTH-1:0]   box_tag;

	modport source (
		output valid, box_min_x, box_min_y, box_min_z,
		output box_max_x, box_max_y, box_max_z, box_tag,
		input  ready
	);
	modport sink (
		input  valid, box_min_x, box_min_y, box_min_z,
		input  box_max_x, box_max_y, box_max_z, box_tag,
		output ready
	);
endinterface

interface afc_res_if;
	import afc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [TAG_WIDTH-1:0] result_tag;
	logic                 visible;

	modport source (
		output valid, result_tag, visible,
		input  ready
	);
	modport sink (
		input  valid, result_tag, visible,
		output ready
	);
endinterface

// ===== rtl/core/aabb_frustum_cull_test_unit.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_unit - six-plane box cull
// Tests each incoming box against the six configured planes.
// ----------------------------------------------------------------------------
// Usage:
//   box  : valid/ready sink; one word holds min and max corner and a tag.
//   res  : valid/ready source; one word per box, tag and visible bit, in order.
//   cfg  : cfg_we writes cfg_wdata to plane cfg_index (0 left .. 5 far);
//          other indices are ignored. Write only while no box is in flight.
// A box is visible when every plane has a corner with a*x+b*y+c*z+d > 0.
// The datapath is a row of six plane cells, two register stages each; a box
// word is registered in each stage in turn on its way to res. One box per
// cycle is sustained while res is ready; each cell stage carries one word.
// Reset clears all planes to zero, so every box is culled until written, and
// empties the pipeline. When res stalls, words stay in their stages and the
// box channel keeps taking words while any stage of the row is free; ready
// only falls once all twelve stages are full.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test_unit #(
	parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	afc_box_if.sink                              box,
	afc_res_if.source                            res,
	input  logic                                 cfg_we,
	input  logic [afc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [afc_pkg::PLANE_WIDTH-1:0]      cfg_wdata
);
	import afc_pkg::*;

	logic [PLANE_WIDTH-1:0]                 plane_q [PLANE_COUNT];
	logic                                   c_valid [PLANE_COUNT+1];
	logic                                   c_ready [PLANE_COUNT+1];
	logic [AXIS_COUNT-1:0][COORD_WIDTH-1:0] c_lo    [PLANE_COUNT+1];
	logic [AXIS_COUNT-1:0][COORD_WIDTH-1:0] c_hi    [PLANE_COUNT+1];
	logic [TAG_WIDTH-1:0]                   c_tag   [PLANE_COUNT+1];
	logic                                   c_vis   [PLANE_COUNT+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_COUNT; i++)
				plane_q[i] <= '0;
		end else if (cfg_we && cfg_index < CFG_INDEX_WIDTH'(PLANE_COUNT)) begin
			plane_q[cfg_index] <= cfg_wdata;
		end
	end

	assign c_valid[0] = box.valid;
	assign box.ready  = c_ready[0];
	assign c_lo[0]    = {box.box_min_z, box.box_min_y, box.box_min_x};
	assign c_hi[0]    = {box.box_max_z, box.box_max_y, box.box_max_x};
	assign c_tag[0]   = box.box_tag;
	assign c_vis[0]   = 1'b1;

	for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
		afc_plane_cell #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.plane     (plane_q[g]),
			.in_valid  (c_valid[g]),
			.in_ready  (c_ready[g]),
			.in_lo     (c_lo[g]),
			.in_hi     (c_hi[g]),
			.in_tag    (c_tag[g]),
			.in_vis    (c_vis[g]),
			.out_valid (c_valid[g+1]),
			.out_ready (c_ready[g+1]),
			.out_lo    (c_lo[g+1]),
			.out_hi    (c_hi[g+1]),
			.out_tag   (c_tag[g+1]),
			.out_vis   (c_vis[g+1])
		);
	end

	assign res.valid          = c_valid[PLANE_COUNT];
	assign c_ready[PLANE_COUNT] = res.ready;
	assign res.result_tag     = c_tag[PLANE_COUNT];
	assign res.visible        = c_vis[PLANE_COUNT];

endmodule

// ===== rtl/core/afc_plane_cell.sv =====
// ----------------------------------------------------------------------------
// afc_plane_cell - one plane test in the cull chain
// Stage 1 forms a*x for min and max on each axis; stage 2 keeps the larger
// per axis, adds d and ANDs (sum > 0) into the running visible flag.
// ----------------------------------------------------------------------------
module afc_plane_cell #(
	parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic [afc_pkg::PLANE_WIDTH-1:0]                   plane,
	input  logic                                              in_valid,
	output logic                                              in_ready,
	input  logic [afc_pkg::AXIS_COUNT-1:0][COORD_WIDTH-1:0]   in_lo,
	input  logic [afc_pkg::AXIS_COUNT-1:0][COORD_WIDTH-1:0]   in_hi,
	input  logic [afc_pkg::TAG_WIDTH-1:0]                     in_tag,
	input  logic                                              in_vis,
	output logic                                              out_valid,
	input  logic                                              out_ready,
	output logic [afc_pkg::AXIS_COUNT-1:0][COORD_WIDTH-1:0]   out_lo,
	output logic [afc_pkg::AXIS_COUNT-1:0][COORD_WIDTH-1:0]   out_hi,
	output logic [afc_pkg::TAG_WIDTH-1:0]                     out_tag,
	output logic                                              out_vis
);
	import afc_pkg::*;

	localparam int PW = COORD_WIDTH + COEF_WIDTH;
	localparam int SW = PW + 2;

	logic                                     v_s1, v_s2;
	logic                                     adv1, adv2;
	logic signed [PW-1:0]                     plo_s1 [AXIS_COUNT];
	logic signed [PW-1:0]                     phi_s1 [AXIS_COUNT];
	logic [AXIS_COUNT-1:0][COORD_WIDTH-1:0]   lo_s1, hi_s1, lo_s2, hi_s2;
	logic [TAG_WIDTH-1:0]                     tag_s1, tag_s2;
	logic                                     vis_s1, vis_s2;
	logic signed [PW-1:0]                     best [AXIS_COUNT];
	logic signed [SW-1:0]                     sum;
	logic [COEF_WIDTH-1:0]                    coef [AXIS_COUNT];
	logic [COEF_WIDTH-1:0]                    coef_d;

	assign coef[0] = coef_at(plane, COEF_A);
	assign coef[1] = coef_at(plane, COEF_B);
	assign coef[2] = coef_at(plane, COEF_C);
	assign coef_d  = coef_at(plane, COEF_D);

	assign adv2     = !v_s2 || out_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			for (int i = 0; i < AXIS_COUNT; i++) begin
				plo_s1[i] <= $signed({{COORD_WIDTH{coef[i][COEF_WIDTH-1]}}, coef[i]}) *
					$signed({{COEF_WIDTH{in_lo[i][COORD_WIDTH-1]}}, in_lo[i]});
				phi_s1[i] <= $signed({{COORD_WIDTH{coef[i][COEF_WIDTH-1]}}, coef[i]}) *
					$signed({{COEF_WIDTH{in_hi[i][COORD_WIDTH-1]}}, in_hi[i]});
			end
			lo_s1  <= in_lo;
			hi_s1  <= in_hi;
			tag_s1 <= in_tag;
			vis_s1 <= in_vis;
		end
	end

	// best corner per axis, independent of min/max ordering
	always_comb begin
		for (int i = 0; i < AXIS_COUNT; i++)
			best[i] = (phi_s1[i] > plo_s1[i]) ? phi_s1[i] : plo_s1[i];
		sum = $signed({{2{best[0][PW-1]}}, best[0]}) +
			$signed({{2{best[1][PW-1]}}, best[1]}) +
			$signed({{2{best[2][PW-1]}}, best[2]}) +
			$signed({{(SW-COEF_WIDTH){coef_d[COEF_WIDTH-1]}}, coef_d});
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			lo_s2  <= lo_s1;
			hi_s2  <= hi_s1;
			tag_s2 <= tag_s1;
			vis_s2 <= vis_s1 && (sum > $signed(SW'(0)));
		end
	end

	assign out_valid = v_s2;
	assign out_lo    = lo_s2;
	assign out_hi    = hi_s2;
	assign out_tag   = tag_s2;
	assign out_vis   = vis_s2;

	a_zero_plane_culls: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && v_s1 && plane == '0) |=> !vis_s2)
		else $error("all-zero plane let a box through");

	a_culled_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && v_s1 && !vis_s1) |=> !vis_s2)
		else $error("culled box revived in cell");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !out_ready) |=> (v_s2 && $stable(tag_s2) && $stable(vis_s2)))
		else $error("stage 2 word changed under stall");

	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 || !v_s2) |-> in_ready)
		else $error("cell refused a word with a free stage");

endmodule
